[design/assert_macros.svh]
// Concurrent assertion helpers used by the mapper core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while the block is out of reset.
`define GTKM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define GTKM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/gtkm_pkg.sv]
package gtkm_pkg;

  typedef enum logic [2:0] {
    EV_KEY_DOWN   = 3'd0,
    EV_KEY_UP     = 3'd1,
    EV_TOUCH_DOWN = 3'd2,
    EV_TOUCH_MOVE = 3'd3,
    EV_TOUCH_UP   = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    REG_FACE_LAYOUT = 3'd0,
    REG_SURF_WIDTH  = 3'd1,
    REG_SURF_HEIGHT = 3'd2,
    REG_DEADZONE    = 3'd3,
    REG_LEFT_LIMIT  = 3'd4,
    REG_RIGHT_LIMIT = 3'd5
  } reg_index_t;

  localparam logic [14:0] FULL_SCALE  = 15'd32767;
  localparam logic [7:0]  KEY_ACCEPT  = 8'd23;
  localparam logic [7:0]  KEY_BACK    = 8'd4;
  localparam logic [24:0] DEN_WIDE    = 25'(960 * 32767);
  localparam logic [24:0] DEN_NARROW  = 25'(544 * 32767);

  // Fixed button to key table; face buttons are overridden by the layout.
  function automatic logic [7:0] key_lookup(input logic [3:0] btn);
    logic [7:0] code;
    case (btn)
      4'd2:    code = 8'd99;
      4'd3:    code = 8'd100;
      4'd4:    code = 8'd109;
      4'd6:    code = 8'd108;
      4'd9:    code = 8'd102;
      4'd10:   code = 8'd103;
      4'd11:   code = 8'd19;
      4'd12:   code = 8'd20;
      4'd13:   code = 8'd21;
      4'd14:   code = 8'd22;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

  // Coordinate map terms, selected by {stick, y axis}.
  function automatic logic [24:0] coord_base(input logic [1:0] sel);
    logic [24:0] b;
    case (sel)
      2'd0:    b = 25'(192 * 32767);
      2'd1:    b = 25'(75 * 32767);
      2'd2:    b = 25'(786 * 32767);
      default: b = 25'(180 * 32767);
    endcase
    return b;
  endfunction

  function automatic logic signed [8:0] coord_gain(input logic [1:0] sel);
    logic signed [8:0] g;
    case (sel)
      2'd0:    g = 9'sd75;
      2'd1:    g = 9'sd75;
      2'd2:    g = 9'sd155;
      default: g = -9'sd105;
    endcase
    return g;
  endfunction

endpackage

[design/gamepad_to_touch_key_mapper_core.sv]
// One item is in flight at a time.
// Button items: an unmapped button is dropped. The key result is valid
// in the cycle after acceptance.
// Axis items: each of four magnitudes needs no divide at rest, else a 15-step
// divide. Planning follows. Each touch result then has two coordinates, each a
// setup, a multiply and a divide, and then its output.
// The output holds while out_stall is high.
// Synchronous active-low reset restores the register defaults, clears the stored
// axis samples and the touch-active flags; there is no clearing pass.
`include "assert_macros.svh"

module gamepad_to_touch_key_mapper_core
  import gtkm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic        in_pressed,
  input  logic [3:0]  in_button_id,
  input  logic [2:0]  in_axis_id,
  input  logic signed [15:0] in_axis_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_key_code,
  output logic        out_touch_surface,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAG, S_DIV, S_PLAN, S_CINIT, S_CMUL, S_OUT
  } state_t;

  state_t       state_r;
  logic         face_r;
  logic [11:0]  width_r, height_r;
  logic [14:0]  dz_r, llim_r, rlim_r;
  logic [15:0]  axis_r [4];
  logic signed [15:0] mag_r [4];
  logic         lact_r, ract_r;
  logic [1:0]   idx_r;
  logic         neg_r;
  logic         div_mag_r;
  logic [25:0]  rem_r;
  logic [15:0]  low_r;
  logic [15:0]  quo_r;
  logic [24:0]  den_r;
  logic [4:0]   cnt_r;
  logic [36:0]  acc_r;
  logic [24:0]  inner_r;
  logic [11:0]  size_r;
  logic         coord_y_r;
  logic [1:0]   res_idx_r, res_cnt_r;
  event_kind_t  slot_kind_r [3];
  logic         slot_surf_r [3];
  event_kind_t  out_kind_r;
  logic [7:0]   out_key_r;
  logic         out_surf_r;
  logic [15:0]  out_x_r, out_y_r;
  logic         out_last_r;

  // Configuration port.
  logic       cfg_wr;
  reg_index_t cfg_idx;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_index_t'(cfg_paddr[4:2]);

  always_comb begin
    cfg_prdata = 32'd0;
    unique case (cfg_idx)
      REG_FACE_LAYOUT: cfg_prdata = {31'd0, face_r};
      REG_SURF_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_SURF_HEIGHT: cfg_prdata = {20'd0, height_r};
      REG_DEADZONE:    cfg_prdata = {17'd0, dz_r};
      REG_LEFT_LIMIT:  cfg_prdata = {17'd0, llim_r};
      REG_RIGHT_LIMIT: cfg_prdata = {17'd0, rlim_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // Button key lookup.
  logic [7:0] btn_code;
  always_comb begin
    if (in_button_id == {3'd0, ~face_r})      btn_code = KEY_ACCEPT;
    else if (in_button_id == {3'd0, face_r})  btn_code = KEY_BACK;
    else                                      btn_code = key_lookup(in_button_id);
  end

  // Magnitude setup for the stored sample selected by idx_r.
  logic [15:0] raw, absv;
  logic [14:0] mag_m, diff;
  logic [29:0] mag_num;
  logic        at_rest;
  always_comb begin
    raw     = axis_r[idx_r];
    absv    = raw[15] ? (~raw + 16'd1) : raw;
    mag_m   = (raw == 16'h8000) ? FULL_SCALE : absv[14:0];
    at_rest = (mag_m <= dz_r);
    diff    = mag_m - dz_r;
    mag_num = {diff, 15'd0} - {15'd0, diff};
  end

  // Shared restoring divider step: one quotient bit per cycle.
  logic [26:0] div_cat;
  logic        div_bit;
  logic [25:0] rem_nxt;
  logic [15:0] quo_nxt;
  logic [14:0] lim_sel, s_clamp;
  always_comb begin
    div_cat = {rem_r, low_r[15]};
    div_bit = (div_cat >= {2'd0, den_r});
    rem_nxt = div_bit ? 26'(div_cat - {2'd0, den_r}) : div_cat[25:0];
    quo_nxt = {quo_r[14:0], div_bit};
    lim_sel = idx_r[1] ? rlim_r : llim_r;
    s_clamp = (quo_nxt[14:0] > lim_sel) ? lim_sel : quo_nxt[14:0];
  end

  // Result plan for an axis item.
  logic        left_defl, right_defl, left_two, right_two;
  event_kind_t plan_kind [3];
  logic        plan_surf [3];
  logic [1:0]  plan_cnt;
  always_comb begin
    left_defl  = (mag_r[0] != 16'sd0) || (mag_r[1] != 16'sd0);
    right_defl = (mag_r[2] != 16'sd0) || (mag_r[3] != 16'sd0);
    left_two   = left_defl && !lact_r;
    right_two  = right_defl && !ract_r;
    plan_cnt   = 2'd0;
    for (int i = 0; i < 3; i++) begin
      plan_kind[i] = EV_TOUCH_MOVE;
      plan_surf[i] = 1'b0;
    end
    if (left_two) begin
      plan_kind[plan_cnt] = EV_TOUCH_DOWN;
      plan_cnt = plan_cnt + 2'd1;
    end
    if (left_defl) begin
      plan_kind[plan_cnt] = EV_TOUCH_MOVE;
      plan_cnt = plan_cnt + 2'd1;
    end else if (lact_r) begin
      plan_kind[plan_cnt] = EV_TOUCH_UP;
      plan_cnt = plan_cnt + 2'd1;
    end
    // Both sticks starting in one item would overflow; the right one waits.
    if (!(left_two && right_two)) begin
      if (right_two) begin
        plan_kind[plan_cnt] = EV_TOUCH_DOWN;
        plan_surf[plan_cnt] = 1'b1;
        plan_cnt = plan_cnt + 2'd1;
      end
      if (right_defl) begin
        plan_kind[plan_cnt] = EV_TOUCH_MOVE;
        plan_surf[plan_cnt] = 1'b1;
        plan_cnt = plan_cnt + 2'd1;
      end else if (ract_r) begin
        plan_kind[plan_cnt] = EV_TOUCH_UP;
        plan_surf[plan_cnt] = 1'b1;
        plan_cnt = plan_cnt + 2'd1;
      end
    end
  end

  // Coordinate setup: inner = base*32767 + gain*s, never negative.
  logic [1:0]         csel;
  logic signed [15:0] cs;
  logic signed [25:0] cprod, cinner;
  logic [24:0]        cden;
  logic [36:0]        acc_nxt;
  logic [41:0]        ctotal;
  always_comb begin
    csel    = {slot_surf_r[res_idx_r], coord_y_r};
    cs      = (slot_kind_r[res_idx_r] == EV_TOUCH_MOVE) ? mag_r[csel] : 16'sd0;
    cprod   = 26'(coord_gain(csel) * cs);
    cinner  = $signed({1'b0, coord_base(csel)}) + cprod;
    cden    = coord_y_r ? DEN_NARROW : DEN_WIDE;
    acc_nxt = {acc_r[35:0], 1'b0} + (size_r[11] ? {12'd0, inner_r} : 37'd0);
    ctotal  = {1'b0, acc_nxt, 4'd0} + {18'd0, cden[24:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      face_r     <= 1'b0;
      width_r    <= 12'd640;
      height_r   <= 12'd480;
      dz_r       <= 15'd4915;
      llim_r     <= 15'd24903;
      rlim_r     <= 15'd32767;
      for (int i = 0; i < 4; i++) axis_r[i] <= 16'd0;
      lact_r     <= 1'b0;
      ract_r     <= 1'b0;
      res_idx_r  <= 2'd0;
      res_cnt_r  <= 2'd0;
      out_last_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_FACE_LAYOUT: face_r   <= cfg_pwdata[0];
          REG_SURF_WIDTH:  width_r  <= cfg_pwdata[11:0];
          REG_SURF_HEIGHT: height_r <= cfg_pwdata[11:0];
          REG_DEADZONE:    dz_r     <= cfg_pwdata[14:0];
          REG_LEFT_LIMIT:  llim_r   <= cfg_pwdata[14:0];
          REG_RIGHT_LIMIT: rlim_r   <= cfg_pwdata[14:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (!in_func) begin
              if (btn_code != 8'd0) begin
                out_kind_r <= in_pressed ? EV_KEY_DOWN : EV_KEY_UP;
                out_key_r  <= btn_code;
                out_surf_r <= 1'b0;
                out_x_r    <= 16'd0;
                out_y_r    <= 16'd0;
                out_last_r <= 1'b1;
                res_idx_r  <= 2'd0;
                res_cnt_r  <= 2'd1;
                state_r    <= S_OUT;
              end
            end else if (!in_axis_id[2]) begin
              axis_r[in_axis_id[1:0]] <= in_axis_value;
              idx_r   <= 2'd0;
              state_r <= S_MAG;
            end
          end
        end
        S_MAG: begin
          if (at_rest) begin
            mag_r[idx_r] <= 16'sd0;
            idx_r        <= idx_r + 2'd1;
            if (idx_r == 2'd3) state_r <= S_PLAN;
          end else begin
            neg_r     <= raw[15];
            div_mag_r <= 1'b1;
            rem_r     <= {11'd0, mag_num[29:15]};
            low_r     <= {mag_num[14:0], 1'b0};
            den_r     <= {10'd0, FULL_SCALE - dz_r};
            quo_r     <= 16'd0;
            cnt_r     <= 5'd15;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= rem_nxt;
          low_r <= {low_r[14:0], 1'b0};
          quo_r <= quo_nxt;
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            if (div_mag_r) begin
              mag_r[idx_r] <= neg_r ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});
              idx_r        <= idx_r + 2'd1;
              state_r      <= (idx_r == 2'd3) ? S_PLAN : S_MAG;
            end else if (!coord_y_r) begin
              out_x_r   <= quo_nxt;
              coord_y_r <= 1'b1;
              state_r   <= S_CINIT;
            end else begin
              out_y_r    <= quo_nxt;
              out_kind_r <= slot_kind_r[res_idx_r];
              out_surf_r <= slot_surf_r[res_idx_r];
              out_key_r  <= 8'd0;
              out_last_r <= (res_idx_r + 2'd1 == res_cnt_r);
              state_r    <= S_OUT;
            end
          end
        end
        S_PLAN: begin
          for (int i = 0; i < 3; i++) begin
            slot_kind_r[i] <= plan_kind[i];
            slot_surf_r[i] <= plan_surf[i];
          end
          res_cnt_r <= plan_cnt;
          res_idx_r <= 2'd0;
          coord_y_r <= 1'b0;
          lact_r    <= left_defl;
          if (!(left_two && right_two)) ract_r <= right_defl;
          state_r   <= (plan_cnt == 2'd0) ? S_IDLE : S_CINIT;
        end
        S_CINIT: begin
          inner_r   <= cinner[24:0];
          size_r    <= coord_y_r ? height_r : width_r;
          den_r     <= cden;
          acc_r     <= 37'd0;
          div_mag_r <= 1'b0;
          cnt_r     <= 5'd12;
          state_r   <= S_CMUL;
        end
        S_CMUL: begin
          acc_r  <= acc_nxt;
          size_r <= {size_r[10:0], 1'b0};
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            // The rounded quotient stays below 2^16, so the top bits seed the remainder.
            rem_r   <= ctotal[41:16];
            low_r   <= ctotal[15:0];
            quo_r   <= 16'd0;
            cnt_r   <= 5'd16;
            state_r <= S_DIV;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              res_idx_r <= res_idx_r + 2'd1;
              coord_y_r <= 1'b0;
              state_r   <= S_CINIT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = (state_r == S_OUT);
  assign out_event_kind    = out_kind_r;
  assign out_key_code      = out_key_r;
  assign out_touch_surface = out_surf_r;
  assign out_pos_x         = out_x_r;
  assign out_pos_y         = out_y_r;
  assign out_last          = out_last_r;

  logic out_is_key, out_key_ok, last_exp;
  assign out_is_key = (out_event_kind == EV_KEY_DOWN) || (out_event_kind == EV_KEY_UP);
  assign out_key_ok = (out_pos_x == 16'd0) && (out_pos_y == 16'd0) && !out_touch_surface;
  assign last_exp   = (res_idx_r + 2'd1 == res_cnt_r);

  `GTKM_ASSERT(a_busy_stalls, (state_r != S_IDLE) |-> in_stall, "input taken while busy")
  `GTKM_ASSERT(a_key_clean, (out_valid && out_is_key) |-> out_key_ok, "key result has touch data")
  `GTKM_ASSERT(a_last_flag, out_valid |-> (out_last == last_exp), "last flag mismatch")
  `GTKM_ASSERT(a_res_count, res_cnt_r != 2'd3 || res_idx_r != 2'd3, "result slot overrun")
  `GTKM_ASSERT(a_done_idle, (out_valid && out_last && !out_stall) |=> (state_r == S_IDLE),
               "no return to idle after last result")

endmodule
